FILE: rtl/core/stj_pkg.sv
`default_nettype none

package stj_pkg;

	localparam int SLOT_COUNT_DEF = 32;
	localparam int CFG_W          = 6;
	localparam int SLOT_W         = 5;
	localparam int SAMPLES_W      = 16;
	localparam int OP_W           = 4;
	localparam int STATUS_W       = 3;
	localparam int KIND_W         = 2;

	localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = CFG_W'(32);

	typedef enum logic [OP_W-1:0] {
		OP_SUB_BEGIN     = 4'd0,
		OP_SUB_COMMIT    = 4'd1,
		OP_SUB_ABORT     = 4'd2,
		OP_UNSUB_BEGIN   = 4'd3,
		OP_UNSUB_COMMIT  = 4'd4,
		OP_REF_BEGIN     = 4'd5,
		OP_REF_COMMIT    = 4'd6,
		OP_REF_ABORT     = 4'd7,
		OP_DEREF_BEGIN   = 4'd8,
		OP_DEREF_COMMIT  = 4'd9,
		OP_ROLLBACK_PROXY = 4'd10,
		OP_ROLLBACK_TRACE = 4'd11
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_PRECOND     = 3'd1,
		ST_CRASH_INC   = 3'd2,
		ST_CRASH_DEC   = 3'd3,
		ST_CRASH_SUB   = 3'd4,
		ST_CRASH_UNSUB = 3'd5
	} status_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_STATUS = 2'd0,
		KIND_DEREF  = 2'd1,
		KIND_UNSUB  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SLOT,
		S_SCAN,
		S_UNSUB,
		S_FIN
	} state_t;

	// begin bit is bit 0, end bit is bit 1
	localparam logic [1:0] BITS_NONE   = 2'd0;
	localparam logic [1:0] BITS_BEGIN  = 2'd1;
	localparam logic [1:0] BITS_END    = 2'd2;
	localparam logic [1:0] BITS_BOTH   = 2'd3;

	function automatic logic [1:0] need_bits(input logic [OP_W-1:0] op);
		logic [1:0] r;
		case (op)
			OP_SUB_BEGIN:    r = BITS_NONE;
			OP_SUB_COMMIT:   r = BITS_BEGIN;
			OP_SUB_ABORT:    r = BITS_BEGIN;
			OP_UNSUB_BEGIN:  r = BITS_BOTH;
			OP_UNSUB_COMMIT: r = BITS_BEGIN;
			OP_REF_BEGIN:    r = BITS_NONE;
			OP_REF_COMMIT:   r = BITS_BEGIN;
			OP_REF_ABORT:    r = BITS_BEGIN;
			OP_DEREF_BEGIN:  r = BITS_BOTH;
			OP_DEREF_COMMIT: r = BITS_END;
			default:         r = BITS_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] next_bits(input logic [OP_W-1:0] op);
		logic [1:0] r;
		case (op)
			OP_SUB_BEGIN:    r = BITS_BEGIN;
			OP_SUB_COMMIT:   r = BITS_BOTH;
			OP_SUB_ABORT:    r = BITS_NONE;
			OP_UNSUB_BEGIN:  r = BITS_END;
			OP_UNSUB_COMMIT: r = BITS_NONE;
			OP_REF_BEGIN:    r = BITS_BEGIN;
			OP_REF_COMMIT:   r = BITS_BOTH;
			OP_REF_ABORT:    r = BITS_NONE;
			OP_DEREF_BEGIN:  r = BITS_END;
			OP_DEREF_COMMIT: r = BITS_NONE;
			default:         r = BITS_NONE;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/stj_ram.sv
`default_nettype none

module stj_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/slot_transaction_journal_core.sv
// channel   dir  handshake               payload
// s_axis    in   tvalid/tready           tdata: operation, slot_number, max_samples
// m_axis    out  tvalid/tready           tdata: event_slot, event_samples, status,
//                                        still_pending; tuser: kind; tlast: last
// cfg       in   cfg_we                  cfg_wdata: slots_in_use
//
// slot journal ops run as accept and table read, then check and write-back
// rollback scans the slots in order, with a dereference word per fully referenced slot,
// a step when the scan runs to the end, an unsubscribe word if due and the status word
// slot bits live in a 1r1w ram; a per-slot nonzero flag, cleared by reset,
// stands for the ram contents until first written, so no clearing pass
// a stalled output stalls the scan; the input is taken only between items
`default_nettype none

module slot_transaction_journal_core
	import stj_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // operation, slot_number, max_samples
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [31:0] m_axis_tdata,   // event_slot, event_samples, status, still_pending
	output logic       [1:0] m_axis_tuser,   // kind
	output logic             m_axis_tlast,
	input  wire logic        cfg_we,
	input  wire logic  [5:0] cfg_wdata       // slots_in_use
);

	localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW = $clog2(SLOT_COUNT + 1);

	state_t state_q, state_d;

	logic [CFG_W-1:0]     cfg_q;
	logic [OP_W-1:0]      op_q, op_d;
	logic [AW-1:0]        slot_q, slot_d;
	logic [STATUS_W-1:0]  status_q, status_d;
	logic [CW-1:0]        idx_q, idx_d;
	logic [1:0]           sub_q, sub_d;
	logic [SAMPLES_W-1:0] saved_q, saved_d;
	logic                 svalid_q, svalid_d;
	logic [SLOT_COUNT-1:0] nz_q, nz_d, mask;

	logic                 out_valid_q;
	logic [KIND_W-1:0]    o_kind_q, o_kind_d;
	logic [SLOT_W-1:0]    o_slot_q, o_slot_d;
	logic [SAMPLES_W-1:0] o_samp_q, o_samp_d;
	logic [STATUS_W-1:0]  o_stat_q, o_stat_d;
	logic                 o_pend_q, o_last_q, o_last_d;
	logic                 out_load, out_free;

	logic                 ram_we, ram_re;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic [1:0]           ram_wdata, ram_rdata;

	logic                 accept;
	logic [OP_W-1:0]      in_op;
	logic [SLOT_W-1:0]    in_slot;
	logic [SAMPLES_W-1:0] in_samp;
	logic [CW-1:0]        n_eff, idx_inc;
	logic                 slots_pend, scan_done, in_slot_ok;
	logic [1:0]           slot_cur, scan_cur;

	assign in_op   = s_axis_tdata[3:0];
	assign in_slot = s_axis_tdata[8:4];
	assign in_samp = s_axis_tdata[24:9];

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign n_eff = (cfg_q > CFG_W'(SLOT_COUNT)) ? CW'(SLOT_COUNT) : CW'(cfg_q);

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			mask[i] = (CW'(i) < n_eff);
		end
	end

	assign slots_pend = |(nz_q & mask);
	assign in_slot_ok = (7'(in_slot) < 7'(n_eff));
	assign scan_done  = (idx_q >= n_eff);
	assign idx_inc    = idx_q + CW'(1);
	assign slot_cur   = nz_q[slot_q] ? ram_rdata : BITS_NONE;
	assign scan_cur   = nz_q[idx_q[AW-1:0]] ? ram_rdata : BITS_NONE;

	stj_ram #(
		.WIDTH(2),
		.DEPTH(SLOT_COUNT)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// datapath and result words
	always_comb begin
		op_d      = op_q;
		slot_d    = slot_q;
		status_d  = status_q;
		idx_d     = idx_q;
		sub_d     = sub_q;
		saved_d   = saved_q;
		svalid_d  = svalid_q;
		nz_d      = nz_q;
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = BITS_NONE;
		ram_re    = 1'b0;
		ram_raddr = slot_q;
		out_load  = 1'b0;
		o_kind_d  = KIND_STATUS;
		o_slot_d  = '0;
		o_samp_d  = '0;
		o_stat_d  = ST_OK;
		o_last_d  = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_d     = in_op;
					slot_d   = AW'(in_slot);
					status_d = ST_OK;
					idx_d    = '0;
					if (in_op <= OP_UNSUB_COMMIT) begin
						if (sub_q != need_bits(in_op)) begin
							status_d = ST_PRECOND;
						end else begin
							sub_d = next_bits(in_op);
							if (in_op == OP_SUB_BEGIN) begin
								saved_d  = in_samp;
								svalid_d = 1'b1;
							end else if (in_op == OP_UNSUB_COMMIT) begin
								saved_d  = '0;
								svalid_d = 1'b0;
							end
						end
					end else if (in_op <= OP_DEREF_COMMIT) begin
						if (!in_slot_ok) begin
							status_d = ST_PRECOND;
						end
						ram_re    = in_slot_ok;
						ram_raddr = AW'(in_slot);
					end else if (in_op == OP_ROLLBACK_PROXY && sub_q == BITS_NONE
						&& slots_pend) begin
						status_d = ST_PRECOND;
					end else if (in_op == OP_ROLLBACK_PROXY || in_op == OP_ROLLBACK_TRACE) begin
						ram_re    = (n_eff != '0);
						ram_raddr = '0;
					end else begin
						status_d = ST_PRECOND;
					end
				end
			end
			S_SLOT: begin
				if (out_free) begin
					out_load = 1'b1;
					o_last_d = 1'b1;
					if (slot_cur != need_bits(op_q)) begin
						o_stat_d = ST_PRECOND;
					end else begin
						ram_we       = 1'b1;
						ram_waddr    = slot_q;
						ram_wdata    = next_bits(op_q);
						nz_d[slot_q] = (next_bits(op_q) != BITS_NONE);
						o_stat_d     = ST_OK;
					end
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					if (op_q == OP_ROLLBACK_PROXY) begin
						case (sub_q)
							BITS_BEGIN: status_d = ST_CRASH_SUB;
							BITS_END:   status_d = ST_CRASH_UNSUB;
							default:    status_d = ST_OK;
						endcase
					end
				end else begin
					case (scan_cur)
						BITS_BOTH: begin
							if (out_free) begin
								ram_we    = 1'b1;
								ram_waddr = idx_q[AW-1:0];
								ram_wdata = BITS_NONE;
								nz_d[idx_q[AW-1:0]] = 1'b0;
								out_load  = 1'b1;
								o_kind_d  = KIND_DEREF;
								o_slot_d  = SLOT_W'(idx_q);
								idx_d     = idx_inc;
								ram_re    = (idx_inc < n_eff);
								ram_raddr = AW'(idx_inc);
							end
						end
						BITS_BEGIN: status_d = ST_CRASH_INC;
						BITS_END:   status_d = ST_CRASH_DEC;
						default: begin
							idx_d     = idx_inc;
							ram_re    = (idx_inc < n_eff);
							ram_raddr = AW'(idx_inc);
						end
					endcase
				end
			end
			S_UNSUB: begin
				if (out_free) begin
					out_load = 1'b1;
					o_kind_d = KIND_UNSUB;
					o_samp_d = svalid_q ? saved_q : '0;
					sub_d    = BITS_NONE;
					saved_d  = '0;
					svalid_d = 1'b0;
					status_d = ST_OK;
				end
			end
			S_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					o_stat_d = status_q;
					o_last_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_op >= OP_REF_BEGIN && in_op <= OP_DEREF_COMMIT && in_slot_ok) begin
						state_d = S_SLOT;
					end else if ((in_op == OP_ROLLBACK_PROXY && !(sub_q == BITS_NONE
						&& slots_pend)) || in_op == OP_ROLLBACK_TRACE) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_SLOT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					if (op_q == OP_ROLLBACK_PROXY && sub_q == BITS_BOTH) begin
						state_d = S_UNSUB;
					end else begin
						state_d = S_FIN;
					end
				end else if (scan_cur == BITS_BEGIN || scan_cur == BITS_END) begin
					state_d = S_FIN;
				end
			end
			S_UNSUB: begin
				if (out_free) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cfg_q       <= SLOTS_IN_USE_RST;
			sub_q       <= BITS_NONE;
			saved_q     <= '0;
			svalid_q    <= 1'b0;
			nz_q        <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			sub_q    <= sub_d;
			saved_q  <= saved_d;
			svalid_q <= svalid_d;
			nz_q     <= nz_d;
			idx_q    <= idx_d;
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		slot_q   <= slot_d;
		status_q <= status_d;
		if (out_load) begin
			o_kind_q <= o_kind_d;
			o_slot_q <= o_slot_d;
			o_samp_q <= o_samp_d;
			o_stat_q <= o_stat_d;
			o_last_q <= o_last_d;
			o_pend_q <= (sub_d != BITS_NONE) || (|(nz_d & mask));
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, o_pend_q, o_stat_q, o_samp_q, o_slot_q};
	assign m_axis_tuser  = o_kind_q;
	assign m_axis_tlast  = o_last_q;

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_STATUS)
		else $error("closing word is not a status word");

	a_event_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != KIND_STATUS |-> !m_axis_tlast
		&& m_axis_tdata[23:21] == ST_OK)
		else $error("event word carries status or last");

	a_deref_clears: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN && out_load && o_kind_d == KIND_DEREF
		|=> !nz_q[$past(idx_q[AW-1:0])])
		else $error("dereferenced slot not cleared");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == S_SLOT || state_q == S_SCAN)
		else $error("slot ram written outside an operation");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> idx_q <= n_eff)
		else $error("scan index beyond slots in use");

endmodule

`default_nettype wire

FILE: sim/journal_checker.sv
`timescale 1ns / 100ps

module journal_checker
	import stj_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,
	input  logic  [1:0] m_axis_tuser,
	input  logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic  [5:0] cfg_wdata,
	output int          errors,
	output int          outstanding
);

	typedef struct {
		logic [KIND_W-1:0]    kind;
		logic [SLOT_W-1:0]    slot;
		logic [SAMPLES_W-1:0] samples;
		logic [STATUS_W-1:0]  status;
		logic                 pending;
		logic                 last;
	} journal_word_t;

	journal_word_t        due_words[$];
	logic [1:0]           slot_bits[SLOT_COUNT_DEF];
	logic [1:0]           sub_bits;
	logic [SAMPLES_W-1:0] saved_samples;
	logic                 saved_ok;
	logic [CFG_W-1:0]     slots_cfg;

	initial begin
		errors = 0;
		outstanding = 0;
	end

	function automatic int live_slots();
		return (slots_cfg > SLOT_COUNT_DEF) ? SLOT_COUNT_DEF : int'(slots_cfg);
	endfunction

	function automatic logic slots_busy();
		int i;
		for (i = 0; i < live_slots(); i++)
			if (slot_bits[i] != BITS_NONE)
				return 1'b1;
		return 1'b0;
	endfunction

	// {new pattern, required pattern}
	function automatic logic [3:0] bit_rule(input logic [OP_W-1:0] op);
		case (op)
			OP_SUB_BEGIN, OP_REF_BEGIN:     return {BITS_BEGIN, BITS_NONE};
			OP_SUB_COMMIT, OP_REF_COMMIT:   return {BITS_BOTH, BITS_BEGIN};
			OP_SUB_ABORT, OP_REF_ABORT,
			OP_UNSUB_COMMIT:                return {BITS_NONE, BITS_BEGIN};
			OP_UNSUB_BEGIN, OP_DEREF_BEGIN: return {BITS_END, BITS_BOTH};
			OP_DEREF_COMMIT:                return {BITS_NONE, BITS_END};
			default:                        return {BITS_NONE, BITS_NONE};
		endcase
	endfunction

	task automatic push_word(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot,
			input logic [SAMPLES_W-1:0] samples, input logic [STATUS_W-1:0] status,
			input logic last);
		journal_word_t w;
		w.kind = kind;
		w.slot = slot;
		w.samples = samples;
		w.status = status;
		w.pending = (sub_bits != BITS_NONE) || slots_busy();
		w.last = last;
		due_words.push_back(w);
	endtask

	task automatic sweep(output logic [STATUS_W-1:0] st);
		int i;
		int n;
		n = live_slots();
		st = ST_OK;
		for (i = 0; i < n; i++) begin
			if (slot_bits[i] == BITS_BOTH) begin
				slot_bits[i] = BITS_NONE;
				push_word(KIND_DEREF, SLOT_W'(i), '0, ST_OK, 1'b0);
			end else if (slot_bits[i] == BITS_BEGIN) begin
				st = ST_CRASH_INC;
				return;
			end else if (slot_bits[i] == BITS_END) begin
				st = ST_CRASH_DEC;
				return;
			end
		end
	endtask

	task automatic apply_op(input logic [31:0] d);
		logic [OP_W-1:0]      op;
		logic [SLOT_W-1:0]    slot;
		logic [SAMPLES_W-1:0] samples;
		logic [STATUS_W-1:0]  st;
		logic [3:0]           rule;
		logic [SAMPLES_W-1:0] handed;
		op = d[3:0];
		slot = d[8:4];
		samples = d[24:9];
		rule = bit_rule(op);
		st = ST_OK;
		if (op <= OP_UNSUB_COMMIT) begin
			if (sub_bits != rule[1:0]) begin
				st = ST_PRECOND;
			end else begin
				sub_bits = rule[3:2];
				if (op == OP_SUB_BEGIN) begin
					saved_samples = samples;
					saved_ok = 1'b1;
				end else if (op == OP_UNSUB_COMMIT) begin
					saved_samples = '0;
					saved_ok = 1'b0;
				end
			end
		end else if (op <= OP_DEREF_COMMIT) begin
			if (int'(slot) >= live_slots() || slot_bits[slot] != rule[1:0])
				st = ST_PRECOND;
			else
				slot_bits[slot] = rule[3:2];
		end else if (op == OP_ROLLBACK_PROXY) begin
			if (sub_bits == BITS_NONE && slots_busy()) begin
				st = ST_PRECOND;
			end else begin
				sweep(st);
				if (st == ST_OK) begin
					case (sub_bits)
						BITS_BOTH: begin
							handed = saved_ok ? saved_samples : '0;
							sub_bits = BITS_NONE;
							saved_samples = '0;
							saved_ok = 1'b0;
							push_word(KIND_UNSUB, '0, handed, ST_OK, 1'b0);
						end
						BITS_BEGIN: st = ST_CRASH_SUB;
						BITS_END:   st = ST_CRASH_UNSUB;
						default:    st = ST_OK;
					endcase
				end
			end
		end else if (op == OP_ROLLBACK_TRACE) begin
			sweep(st);
		end else begin
			st = ST_PRECOND;
		end
		push_word(KIND_STATUS, '0, '0, st, 1'b1);
	endtask

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t mismatch %s expected %0d actual %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		journal_word_t w;
		if (!arst_n) begin
			foreach (slot_bits[i])
				slot_bits[i] = BITS_NONE;
			sub_bits = BITS_NONE;
			saved_samples = '0;
			saved_ok = 1'b0;
			slots_cfg = SLOTS_IN_USE_RST;
			due_words.delete();
		end else begin
			if (cfg_we)
				slots_cfg = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready)
				apply_op(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_words.size() == 0) begin
					errors++;
					$display("%0t mismatch word expected none actual kind %0d data %h last %0d",
						$time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
				end else begin
					w = due_words.pop_front();
					check_field("kind", w.kind, m_axis_tuser);
					check_field("event_slot", w.slot, m_axis_tdata[4:0]);
					check_field("event_samples", w.samples, m_axis_tdata[20:5]);
					check_field("status", w.status, m_axis_tdata[23:21]);
					check_field("still_pending", w.pending, m_axis_tdata[24]);
					check_field("last", w.last, m_axis_tlast);
				end
			end
		end
		outstanding = due_words.size();
	end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import stj_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic  [1:0] m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_we = 1'b0;
	logic  [5:0] cfg_wdata = '0;
	int          errors;
	int          outstanding;

	int   send_idle_pct = 0;
	int   stall_pct = 0;
	logic hold_req = 1'b0;
	int   cur_slots = 32;
	int   quiet = 0;

	always #10 clk = ~clk;

	slot_transaction_journal_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	journal_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.errors        (errors),
		.outstanding   (outstanding)
	);

	// output side, with one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet <= 0;
			end else begin
				quiet <= quiet + 1;
				if (quiet >= QUIET_LIMIT) begin
					$display("FAIL slot_transaction_journal_core");
					$finish;
				end
			end
		end
	end

	task automatic send_word(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
			input logic [SAMPLES_W-1:0] samples);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, samples, slot, op};
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
	endtask

	task automatic drain_and_set(input int slots);
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= 6'(slots);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_slots = slots;
	endtask

	function automatic logic [SLOT_W-1:0] pick_slot();
		int pool;
		int r;
		pool = (cur_slots < 4) ? cur_slots : 4;
		r = $urandom_range(0, 9);
		if (r < 6)
			return SLOT_W'($urandom_range(0, pool - 1));
		else if (r < 9)
			return SLOT_W'($urandom_range(0, cur_slots - 1));
		return SLOT_W'($urandom_range(0, 31));
	endfunction

	task automatic random_burst(input int n);
		int sent;
		int r;
		logic [SLOT_W-1:0] s;
		sent = 0;
		while (sent < n) begin
			s = pick_slot();
			r = $urandom_range(0, 9);
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5: begin
					send_word(OP_REF_BEGIN, s, 16'($urandom));
					sent++;
					if (r < 6) begin
						send_word(OP_REF_COMMIT, s, 16'($urandom));
						sent++;
					end else if (r < 9) begin
						send_word(OP_REF_ABORT, s, 16'($urandom));
						sent++;
					end
				end
				6, 7, 8: begin
					send_word(OP_DEREF_BEGIN, s, 16'($urandom));
					sent++;
					if (r < 8) begin
						send_word(OP_DEREF_COMMIT, s, 16'($urandom));
						sent++;
					end
				end
				9, 10: begin
					send_word(OP_SUB_BEGIN, s, 16'($urandom));
					send_word((r < 8) ? OP_SUB_COMMIT : OP_SUB_ABORT, s, 16'($urandom));
					sent += 2;
				end
				11: begin
					send_word(OP_UNSUB_BEGIN, s, 16'($urandom));
					sent++;
					if (r < 8) begin
						send_word(OP_UNSUB_COMMIT, s, 16'($urandom));
						sent++;
					end
				end
				12, 13: begin
					send_word((r < 5) ? OP_ROLLBACK_PROXY : OP_ROLLBACK_TRACE, s,
						16'($urandom));
					sent++;
				end
				14, 15, 16: begin
					send_word(OP_W'($urandom_range(OP_REF_BEGIN, OP_DEREF_COMMIT)), s,
						16'($urandom));
					sent++;
				end
				default: begin
					send_word(OP_W'($urandom_range(0, 15)), SLOT_W'($urandom_range(0, 31)),
						16'($urandom));
					sent++;
				end
			endcase
		end
	endtask

	task automatic directed_words();
		send_word(OP_SUB_BEGIN, 5'd0, 16'hFFFF);
		send_word(OP_SUB_BEGIN, 5'd31, 16'h0000);
		send_word(OP_SUB_ABORT, 5'd0, 16'h0000);
		send_word(OP_SUB_BEGIN, 5'd0, 16'hFFFF);
		send_word(OP_SUB_COMMIT, 5'd0, 16'h0000);
		send_word(OP_REF_BEGIN, 5'd0, 16'h0000);
		send_word(OP_REF_COMMIT, 5'd0, 16'h0000);
		send_word(OP_REF_BEGIN, 5'd31, 16'hFFFF);
		send_word(OP_REF_COMMIT, 5'd31, 16'h0000);
		send_word(OP_REF_BEGIN, 5'd5, 16'h0000);
		// deref event for slot 0, then stop at the half-done slot
		send_word(OP_ROLLBACK_TRACE, 5'd0, 16'h0000);
		send_word(OP_REF_ABORT, 5'd5, 16'h0000);
		send_word(OP_DEREF_BEGIN, 5'd31, 16'h0000);
		send_word(OP_ROLLBACK_PROXY, 5'd0, 16'h0000);
		send_word(OP_DEREF_COMMIT, 5'd31, 16'h0000);
		// committed subscription undone with unsubscribe event
		send_word(OP_ROLLBACK_PROXY, 5'd0, 16'h0000);
		send_word(OP_ROLLBACK_PROXY, 5'd0, 16'h0000);
		// proxy rollback with slot busy and no subscription
		send_word(OP_REF_BEGIN, 5'd2, 16'h0000);
		send_word(OP_ROLLBACK_PROXY, 5'd0, 16'h0000);
		send_word(OP_REF_ABORT, 5'd2, 16'h0000);
		send_word(OP_SUB_BEGIN, 5'd0, 16'h0000);
		send_word(OP_ROLLBACK_PROXY, 5'd0, 16'h0000);
		send_word(OP_SUB_COMMIT, 5'd0, 16'h0000);
		send_word(OP_UNSUB_BEGIN, 5'd0, 16'h0000);
		send_word(OP_ROLLBACK_PROXY, 5'd0, 16'h0000);
		send_word(OP_UNSUB_COMMIT, 5'd0, 16'h0000);
		send_word(OP_UNUSED_HI, 5'd31, 16'hFFFF);
	endtask

	initial begin
		int slots_seq[8];
		int mode_seq[8];
		int p;
		slots_seq = '{32, 1, 32, 7, 20, 32, 3, 32};
		mode_seq = '{0, 1, 2, 3, 0, 3, 2, 1};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (p = 0; p < 8; p++) begin
			drain_and_set(slots_seq[p]);
			case (mode_seq[p])
				1: begin
					send_idle_pct = 68;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 68;
				end
				3: begin
					send_idle_pct = 21;
					stall_pct = 21;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			if (p == 2)
				hold_req = 1'b1;
			if (p == 0)
				directed_words();
			random_burst(37);
		end
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (64) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("PASS slot_transaction_journal_core");
		else
			$display("FAIL slot_transaction_journal_core");
		$finish;
	end

endmodule
